[src/mtlb_pkg.sv]
package mtlb_pkg;

    typedef enum logic [2:0] {
        CMD_LOAD    = 3'd0,
        CMD_STORE   = 3'd1,
        CMD_WR_IDX  = 3'd2,
        CMD_WR_RAND = 3'd3,
        CMD_READ    = 3'd4,
        CMD_PROBE   = 3'd5,
        CMD_TICK    = 3'd6,
        CMD_NOP     = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ADDR_ERR = 3'd1,
        ST_REFILL   = 3'd2,
        ST_INVALID  = 3'd3,
        ST_MODIFIED = 3'd4,
        ST_INDEX    = 3'd5
    } status_t;

    localparam logic [0:0] REG_TICK_DIVISOR = 1'b0;
    localparam logic [0:0] REG_WIRED_COUNT  = 1'b1;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] virt_addr;
        logic        privileged;
        logic [31:0] entry_hi;
        logic [31:0] page_mask;
        logic [31:0] entry_lo_even;
        logic [31:0] entry_lo_odd;
        logic [5:0]  entry_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [37:0] phys_addr;
        logic        probe_hit;
        logic [5:0]  probe_index;
        logic [31:0] read_entry_hi;
        logic [31:0] read_page_mask;
        logic [31:0] read_lo_even;
        logic [31:0] read_lo_odd;
    } out_item_t;

    // One TLB entry as stored in a cell.
    typedef struct packed {
        logic [18:0] vpn2;
        logic [7:0]  asid;
        logic [11:0] mask;
        logic [4:0]  shift;
        logic        is_global;
        logic [25:0] pfn_odd;
        logic [25:0] pfn_even;
        logic [4:0]  flags_odd;   // cache[4:2], dirty[1], valid[0]
        logic [4:0]  flags_even;
    } entry_t;

    // Lookup token passed down the cell chain.
    typedef struct packed {
        logic        found;
        logic [5:0]  index;
        entry_t      entry;
    } search_t;

    function automatic entry_t make_entry(logic [31:0] eh, logic [31:0] pm,
                                          logic [31:0] lo0, logic [31:0] lo1);
        entry_t e;
        logic [18:0] p;
        e.vpn2 = eh[31:13];
        e.asid = eh[7:0];
        p = pm[31:13];
        e.mask = '0;
        e.shift = 5'd12;
        for (int i = 0; i <= 12; i += 2) begin
            if (p == 19'((32'd1 << i) - 32'd1) && e.mask == '0 && e.shift == 5'd12) begin
                e.mask = 12'(p);
                e.shift = 5'(12 + i);
            end
        end
        e.is_global = lo0[0];
        e.pfn_even = lo0[31:6];
        e.pfn_odd = lo1[31:6];
        e.flags_even = {lo0[5:3], lo0[2], lo0[1]};
        e.flags_odd = {lo1[5:3], lo1[2], lo1[1]};
        return e;
    endfunction

endpackage

[src/mtlb_cell.sv]
module mtlb_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [5:0]        my_index,
    input  logic              wr_en,
    input  mtlb_pkg::entry_t  wr_entry,
    input  logic [18:0]       key_vpn2,
    input  logic [7:0]        key_asid,
    input  logic [5:0]        rd_index,
    input  mtlb_pkg::search_t chain_in,
    output mtlb_pkg::search_t chain_out,
    output mtlb_pkg::entry_t  rd_tap
);
    import mtlb_pkg::*;

    entry_t      entry_reg;
    logic [18:0] m;
    logic        hit;
    logic        rd_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else if (wr_en)
            entry_reg <= wr_entry;
    end

    always_comb
    begin
        m = ~{7'd0, entry_reg.mask};
        hit = ((entry_reg.vpn2 & m) == (key_vpn2 & m)) &&
              (entry_reg.asid == key_asid || entry_reg.is_global);
        rd_sel = (rd_index == my_index);
        chain_out = chain_in;
        if (!chain_in.found && hit)
        begin
            chain_out.found = 1'b1;
            chain_out.index = my_index;
            chain_out.entry = entry_reg;
        end
        rd_tap = rd_sel ? entry_reg : '0;
    end
endmodule

[src/mips_tlb_translate_and_manage.sv]
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    mtlb_pkg::in_item_t
// out       output     out_valid/out_stall  mtlb_pkg::out_item_t
// cfg       input      cfg_we               cfg_index, cfg_data
// Each item is first registered (command and search key), then passes through the
// chain of entry cells (lowest matching cell wins) into the output register.
// The result waits in an output register; the next item is accepted while it waits.
// Reset clears all entries, the random index, wired count and prescaler, and sets the divisor to one.
// A stalled output holds the result; once a second item waits behind it, input stalls.
module mips_tlb_translate_and_manage #(
    parameter int TLB_ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mtlb_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mtlb_pkg::out_item_t   out_item,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_data
);
    import mtlb_pkg::*;

    localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    in_item_t  req_reg;
    logic      req_valid_reg;
    logic [7:0] divisor_reg;
    logic [5:0] wired_reg;
    logic [IW-1:0] random_reg;
    logic [7:0] prescale_reg;
    out_item_t res_reg, res_next;
    logic      res_valid_reg;

    search_t chain [TLB_ENTRIES+1];
    entry_t  taps  [TLB_ENTRIES];
    entry_t  rd_or [TLB_ENTRIES+1];
    entry_t  new_entry;
    logic [5:0] wr_idx;
    logic       wr_do;
    logic       fire_in, fire_work;
    cmd_t       cmd;
    logic [18:0] key_vpn2;

    assign cmd = cmd_t'(req_reg.command);
    assign fire_work = req_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !fire_work;
    assign fire_in = in_valid && !in_stall;
    assign out_valid = res_valid_reg;
    assign out_item = res_reg;

    assign key_vpn2 = (cmd == CMD_PROBE) ? req_reg.entry_hi[31:13] : req_reg.virt_addr[31:13];
    assign new_entry = make_entry(req_reg.entry_hi, req_reg.page_mask,
                                  req_reg.entry_lo_even, req_reg.entry_lo_odd);
    assign wr_idx = (cmd == CMD_WR_RAND) ? 6'(random_reg) : req_reg.entry_index;
    assign wr_do = fire_work && (cmd == CMD_WR_IDX || cmd == CMD_WR_RAND) &&
                   ({1'b0, wr_idx} < 7'(TLB_ENTRIES));

    assign chain[0] = '0;
    assign rd_or[0] = '0;
    for (genvar g = 0; g < TLB_ENTRIES; g++)
    begin : g_cell
        mtlb_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_index (6'(g)),
            .wr_en    (wr_do && wr_idx == 6'(g)),
            .wr_entry (new_entry),
            .key_vpn2 (key_vpn2),
            .key_asid (req_reg.entry_hi[7:0]),
            .rd_index (req_reg.entry_index),
            .chain_in (chain[g]),
            .chain_out(chain[g+1]),
            .rd_tap   (taps[g])
        );
        assign rd_or[g+1] = rd_or[g] | taps[g];
    end

    always_comb
    begin
        logic [31:0] va;
        logic        odd;
        logic [4:0]  f;
        logic [25:0] pfn;
        logic [37:0] mk;
        entry_t      e, r;
        va = req_reg.virt_addr;
        e = chain[TLB_ENTRIES].entry;
        r = rd_or[TLB_ENTRIES];
        odd = va[e.shift];
        f = odd ? e.flags_odd : e.flags_even;
        pfn = odd ? e.pfn_odd : e.pfn_even;
        mk = {~{14'd0, e.mask}, 12'd0};
        res_next = '0;
        case (cmd)
            CMD_LOAD, CMD_STORE:
            begin
                if (va[31] && !req_reg.privileged)
                    res_next.status = ST_ADDR_ERR;
                else if (va[31:30] == 2'b10)
                    res_next.phys_addr = {9'd0, va[28:0]};
                else if (!chain[TLB_ENTRIES].found)
                    res_next.status = ST_REFILL;
                else if (!f[0])
                    res_next.status = ST_INVALID;
                else if (cmd == CMD_STORE && !f[1])
                    res_next.status = ST_MODIFIED;
                else
                    res_next.phys_addr = ({pfn, 12'd0} & mk) | ({6'd0, va} & ~mk);
            end
            CMD_WR_IDX, CMD_WR_RAND:
                if ({1'b0, wr_idx} >= 7'(TLB_ENTRIES))
                    res_next.status = ST_INDEX;
            CMD_READ:
                if ({1'b0, req_reg.entry_index} >= 7'(TLB_ENTRIES))
                    res_next.status = ST_INDEX;
                else
                begin
                    res_next.read_entry_hi = {r.vpn2, 5'd0, r.asid};
                    res_next.read_page_mask = {7'd0, r.mask, 13'd0};
                    res_next.read_lo_even = {r.pfn_even, r.flags_even[4:2],
                                             r.flags_even[1], r.flags_even[0], r.is_global};
                    res_next.read_lo_odd = {r.pfn_odd, r.flags_odd[4:2],
                                            r.flags_odd[1], r.flags_odd[0], r.is_global};
                end
            CMD_PROBE:
            begin
                res_next.probe_hit = chain[TLB_ENTRIES].found;
                res_next.probe_index = chain[TLB_ENTRIES].index;
            end
            default:
                res_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [7:0] pc;
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            divisor_reg <= 8'd1;
            wired_reg <= '0;
            random_reg <= '0;
            prescale_reg <= '0;
        end
        else
        begin
            pc = prescale_reg + 8'd1;
            if (cfg_we)
            begin
                if (cfg_index == REG_TICK_DIVISOR)
                    divisor_reg <= cfg_data;
                else
                    wired_reg <= cfg_data[5:0];
            end
            if (fire_in)
                req_valid_reg <= 1'b1;
            else if (fire_work)
                req_valid_reg <= 1'b0;
            if (fire_work)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
            if (fire_work && cmd == CMD_TICK)
            begin
                if (pc >= divisor_reg)
                begin
                    prescale_reg <= '0;
                    if ({{(8-IW){1'b0}}, random_reg} <= {2'd0, wired_reg})
                        random_reg <= IW'(TLB_ENTRIES - 1);
                    else
                        random_reg <= random_reg - 1'b1;
                end
                else
                    prescale_reg <= pc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_in)
            req_reg <= in_item;
        if (fire_work)
            res_reg <= res_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && res_valid_reg && out_stall |-> in_stall)
        else $error("input accepted while pipeline full");
    a_work_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire_work |=> out_valid)
        else $error("work lost");
    a_random: assert property (@(posedge clk) disable iff (!rst_n)
        32'(random_reg) < TLB_ENTRIES)
        else $error("random index out of range");
endmodule
